### hw/rtl/assert_macros.svh
// Assertion macros shared by the column map filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at any clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### hw/rtl/cme_pkg.sv
// Shared types and constants of the column map filter.
package cme_pkg;

  // Default number of source columns held in the map.
  localparam int MAX_COLS_DEFAULT = 1024;

  // Field widths.
  localparam int COL_W   = 10;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 24;
  localparam int MAP_W   = COL_W + 1;

  // Saturation value of the kept-word count.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_MAP        = 2'd0,
    OP_UNMAP      = 2'd1,
    OP_ENTRY      = 2'd2,
    OP_NEW_MATRIX = 2'd3
  } op_t;

  // Classified work item handed from front to back.
  typedef struct packed {
    logic             is_new;
    logic             kept;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             row_end;
  } q_item_t;

  // Push request from the front into the queue.
  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

endpackage

### hw/rtl/cme_ram.sv
// Generic simple dual-port RAM with registered read.
module cme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cme_front.sv
// Front part: accepts words, keeps the column map and classifies entries.
`include "assert_macros.svh"

module cme_front import cme_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              entry_valid,
  output logic              entry_stall,
  input  logic [1:0]        op,
  input  logic [COL_W-1:0]  column,
  input  logic [COL_W-1:0]  new_column,
  input  logic [VAL_W-1:0]  entry_value,
  input  logic              row_end,
  input  logic [QCW-1:0]    q_count,
  output q_push_t           q_push
);

  localparam int AW = $clog2(MAX_COLS);

  op_t              op_in;
  logic             accept;
  logic             in_range;
  logic             map_we;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MAP_W-1:0] ram_wdata;
  logic [MAP_W-1:0] ram_rdata;
  logic             clr_active;
  logic [AW-1:0]    clr_addr;
  logic             s1_valid;
  logic             s1_new;
  logic             s1_in_range;
  logic [VAL_W-1:0] s1_value;
  logic             s1_row_end;
  logic             s1_kept;

  assign op_in    = op_t'(op);
  assign in_range = (32'(column) < 32'(MAX_COLS));

  // Stall while the map is being cleared or the queue may lack room.
  assign entry_stall = clr_active || ((q_count + QCW'(s1_valid)) >= QCW'(QDEPTH));
  assign accept      = entry_valid && !entry_stall;

  // Clearing pass over the map after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_COLS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // In-range map and unmap words write the map directly.
  assign map_we    = accept && in_range && (op_in == OP_MAP || op_in == OP_UNMAP);
  assign ram_we    = clr_active || map_we;
  assign ram_waddr = clr_active ? clr_addr : AW'(column);
  assign ram_wdata = (!clr_active && op_in == OP_MAP) ? {1'b1, new_column} : '0;

  cme_ram #(
    .WIDTH(MAP_W),
    .DEPTH(MAX_COLS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(column)),
    .rdata(ram_rdata)
  );

  // Lookup stage: holds the word while the map read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (op_in == OP_ENTRY || op_in == OP_NEW_MATRIX);
    end
  end

  always_ff @(posedge clk) begin
    s1_new      <= (op_in == OP_NEW_MATRIX);
    s1_in_range <= in_range;
    s1_value    <= entry_value;
    s1_row_end  <= row_end;
  end

  // Classify the entry from the map contents and push it.
  assign s1_kept = !s1_new && s1_in_range && ram_rdata[MAP_W-1];

  always_comb begin
    q_push.push         = s1_valid;
    q_push.item.is_new  = s1_new;
    q_push.item.kept    = s1_kept;
    q_push.item.col     = s1_kept ? ram_rdata[COL_W-1:0] : '0;
    q_push.item.value   = s1_kept ? s1_value : '0;
    q_push.item.row_end = s1_row_end;
  end

  `ASSERT_CHK(a_push_room, clk, rst, s1_valid |-> (q_count < QCW'(QDEPTH)),
              "front: push into a full queue")
  `ASSERT_NEVER(a_map_write_in_clear, clk, rst, clr_active && map_we,
                "front: map write taken during clearing pass")

endmodule

### hw/rtl/cme_queue.sv
// Short queue of classified items between front and back.
`include "assert_macros.svh"

module cme_queue import cme_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  q_push_t        q_push,
  input  logic           pop,
  output q_item_t        head,
  output logic [QCW-1:0] count
);

  q_item_t        slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign head = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + QCW'(q_push.push) - QCW'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.item;
    end
  end

  `ASSERT_NEVER(a_overflow, clk, rst, q_push.push && count == QCW'(QDEPTH),
                "queue: push while full")
  `ASSERT_NEVER(a_underflow, clk, rst, pop && count == '0,
                "queue: pop while empty")

endmodule

### hw/rtl/cme_back.sv
// Back part: keeps the kept-word count and drives the result register.
`include "assert_macros.svh"

module cme_back import cme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_item_t           head,
  input  logic [QCW-1:0]    q_count,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              kept,
  output logic [COL_W-1:0]  out_column,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_row_end,
  output logic [CNT_W-1:0]  row_pointer
);

  logic             q_valid;
  logic             emit;
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] kept_count_next;

  assign q_valid = (q_count != '0);

  // A new-matrix item never needs the result register; an entry needs it free.
  assign pop  = q_valid && (head.is_new || !result_valid || !result_stall);
  assign emit = pop && !head.is_new;

  always_comb begin
    if (head.is_new) begin
      kept_count_next = '0;
    end else if (head.kept && kept_count != CNT_MAX) begin
      kept_count_next = kept_count + CNT_W'(1);
    end else begin
      kept_count_next = kept_count;
    end
  end

  // Count and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        kept_count <= kept_count_next;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (emit) begin
      kept        <= head.kept;
      out_column  <= head.col;
      out_value   <= head.value;
      out_row_end <= head.row_end;
      row_pointer <= kept_count_next;
    end
  end

  `ASSERT_CHK(a_dropped_zero, clk, rst,
              (result_valid && !kept) |-> (out_column == '0 && out_value == '0),
              "back: dropped entry carries nonzero column or value")
  `ASSERT_CHK(a_count_step, clk, rst,
              (emit && head.kept && kept_count != CNT_MAX) |=>
                (kept_count == $past(kept_count) + CNT_W'(1)),
              "back: kept entry did not advance the count")

endmodule

### hw/rtl/csr_column_map_extract.sv
// Top level of the column map filter for compressed-sparse-row entries.
// The block takes one word per cycle while entry_stall is low and returns one
// result word for each matrix entry, with map, unmap and new-matrix words
// producing no result. An entry word passes the map lookup stage, whose
// registered RAM read feeds the classification, then a four-deep queue, and
// then the back stage, which updates the saturating kept count and loads the
// result register. After reset a clearing pass marks every map entry
// unmapped, one per cycle, and entry_stall stays high until the pass ends.
module csr_column_map_extract import cme_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              entry_valid,
  output logic              entry_stall,
  input  logic [1:0]        op,
  input  logic [COL_W-1:0]  column,
  input  logic [COL_W-1:0]  new_column,
  input  logic [VAL_W-1:0]  entry_value,
  input  logic              row_end,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              kept,
  output logic [COL_W-1:0]  out_column,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_row_end,
  output logic [CNT_W-1:0]  row_pointer
);

  q_push_t        q_push;
  q_item_t        q_head;
  logic [QCW-1:0] q_count;
  logic           q_pop;

  cme_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .entry_valid(entry_valid),
    .entry_stall(entry_stall),
    .op         (op),
    .column     (column),
    .new_column (new_column),
    .entry_value(entry_value),
    .row_end    (row_end),
    .q_count    (q_count),
    .q_push     (q_push)
  );

  cme_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_push(q_push),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  cme_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_count     (q_count),
    .pop         (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kept        (kept),
    .out_column  (out_column),
    .out_value   (out_value),
    .out_row_end (out_row_end),
    .row_pointer (row_pointer)
  );

endmodule
